[hdl/tan_pkg.sv]
// Shared constants for the triangle area and unit normal pipeline.
package tan_pkg;

  localparam int TAN_COORD_WIDTH      = 24;
  localparam int TAN_NORMAL_FRAC_BITS = 14;

endpackage

[hdl/tan_cross.sv]
// Edge differences, partial products and cross product magnitude and sign.
module tan_cross #(
  parameter int COORD_WIDTH = tan_pkg::TAN_COORD_WIDTH,
  parameter int CM          = 2 * COORD_WIDTH + 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] v0_x,
  input  logic signed [COORD_WIDTH-1:0] v0_y,
  input  logic signed [COORD_WIDTH-1:0] v0_z,
  input  logic signed [COORD_WIDTH-1:0] v1_x,
  input  logic signed [COORD_WIDTH-1:0] v1_y,
  input  logic signed [COORD_WIDTH-1:0] v1_z,
  input  logic signed [COORD_WIDTH-1:0] v2_x,
  input  logic signed [COORD_WIDTH-1:0] v2_y,
  input  logic signed [COORD_WIDTH-1:0] v2_z,
  output logic                          out_valid,
  output logic [2:0][CM-1:0]            c_mag,
  output logic [2:0]                    c_neg
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int CW = PW + 1;

  logic [2:0]              v_r;
  logic signed [DW-1:0]    a_r [3];
  logic signed [DW-1:0]    b_r [3];
  logic signed [PW-1:0]    p_r [6];
  logic [2:0][CM-1:0]      mag_r, mag_nxt;
  logic [2:0]              neg_r, neg_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0] <= DW'(v1_x) - DW'(v0_x);
      a_r[1] <= DW'(v1_y) - DW'(v0_y);
      a_r[2] <= DW'(v1_z) - DW'(v0_z);
      b_r[0] <= DW'(v2_x) - DW'(v1_x);
      b_r[1] <= DW'(v2_y) - DW'(v1_y);
      b_r[2] <= DW'(v2_z) - DW'(v1_z);
      p_r[0] <= a_r[1] * b_r[2];
      p_r[1] <= a_r[2] * b_r[1];
      p_r[2] <= a_r[2] * b_r[0];
      p_r[3] <= a_r[0] * b_r[2];
      p_r[4] <= a_r[0] * b_r[1];
      p_r[5] <= a_r[1] * b_r[0];
      mag_r  <= mag_nxt;
      neg_r  <= neg_nxt;
    end
  end

  always_comb begin
    logic signed [CW-1:0] c;
    logic signed [CW-1:0] ca;
    for (int i = 0; i < 3; i++) begin
      c          = CW'(p_r[2*i]) - CW'(p_r[2*i+1]);
      ca         = c[CW-1] ? -c : c;
      neg_nxt[i] = c[CW-1];
      mag_nxt[i] = ca[CM-1:0];
    end
  end

  assign out_valid = v_r[2];
  assign c_mag     = mag_r;
  assign c_neg     = neg_r;

endmodule

[hdl/tan_square.sv]
// Sum of squares of the cross product components from half-width partial products.
module tan_square #(
  parameter int COORD_WIDTH = tan_pkg::TAN_COORD_WIDTH,
  parameter int CM          = 2 * COORD_WIDTH + 2,
  parameter int SW          = 2 * CM
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [2:0][CM-1:0] c_mag,
  input  logic [2:0]         c_neg,
  output logic               out_valid,
  output logic [SW-1:0]      s,
  output logic [2:0][CM-1:0] c_mag_out,
  output logic [2:0]         c_neg_out
);

  localparam int LO = CM / 2;

  logic [2:0]              v_r;
  logic [2:0][CM-1:0]      hh_r, hl_r, ll_r;
  logic [2:0][SW-1:0]      sq_r;
  logic [SW-1:0]           s_r;
  logic [2:0][CM-1:0]      cm_r [3];
  logic [2:0]              cn_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        hh_r[i] <= c_mag[i][CM-1:LO] * c_mag[i][CM-1:LO];
        hl_r[i] <= c_mag[i][CM-1:LO] * c_mag[i][LO-1:0];
        ll_r[i] <= c_mag[i][LO-1:0] * c_mag[i][LO-1:0];
        sq_r[i] <= {hh_r[i], ll_r[i]} + (SW'(hl_r[i]) << (LO + 1));
      end
      s_r     <= sq_r[0] + sq_r[1] + sq_r[2];
      cm_r[0] <= c_mag;
      cn_r[0] <= c_neg;
      cm_r[1] <= cm_r[0];
      cn_r[1] <= cn_r[0];
      cm_r[2] <= cm_r[1];
      cn_r[2] <= cn_r[1];
    end
  end

  assign out_valid = v_r[2];
  assign s         = s_r;
  assign c_mag_out = cm_r[2];
  assign c_neg_out = cn_r[2];

endmodule

[hdl/tan_sqrt.sv]
// Pipelined restoring integer square root, one root bit per stage.
module tan_sqrt #(
  parameter int COORD_WIDTH = tan_pkg::TAN_COORD_WIDTH,
  parameter int CM          = 2 * COORD_WIDTH + 2,
  parameter int SW          = 2 * CM
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [SW-1:0]      s,
  input  logic [2:0][CM-1:0] c_mag,
  input  logic [2:0]         c_neg,
  output logic               out_valid,
  output logic [CM-1:0]      root,
  output logic [2:0][CM-1:0] c_mag_out,
  output logic [2:0]         c_neg_out
);

  localparam int RW = CM + 3;

  logic [CM-1:0]       v_r;
  logic [RW-1:0]       rem_r  [CM-1];
  logic [SW-1:0]       s_r    [CM-1];
  logic [CM-1:0]       root_r [CM];
  logic [2:0][CM-1:0]  cm_r   [CM];
  logic [2:0]          cn_r   [CM];

  for (genvar g = 0; g < CM; g++) begin : g_st
    logic [RW-1:0]      rem_i, r2, trial;
    logic [CM-1:0]      root_i;
    logic [SW-1:0]      s_i;
    logic               vi;
    logic [2:0][CM-1:0] cm_i;
    logic [2:0]         cn_i;
    logic               ge;

    if (g == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign s_i    = s;
      assign vi     = in_valid;
      assign cm_i   = c_mag;
      assign cn_i   = c_neg;
    end else begin : g_next
      assign rem_i  = rem_r[g-1];
      assign root_i = root_r[g-1];
      assign s_i    = s_r[g-1];
      assign vi     = v_r[g-1];
      assign cm_i   = cm_r[g-1];
      assign cn_i   = cn_r[g-1];
    end

    assign r2    = {rem_i[RW-3:0], s_i[SW-1 -: 2]};
    assign trial = {1'b0, root_i, 2'b01};
    assign ge    = (r2 >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[g] <= {root_i[CM-2:0], ge};
        cm_r[g]   <= cm_i;
        cn_r[g]   <= cn_i;
      end
    end

    if (g < CM - 1) begin : g_carry
      logic [RW-1:0] rem_nxt;
      assign rem_nxt = ge ? (r2 - trial) : r2;
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[g] <= rem_nxt;
          s_r[g]   <= {s_i[SW-3:0], 2'b00};
        end
      end
    end
  end

  assign out_valid = v_r[CM-1];
  assign root      = root_r[CM-1];
  assign c_mag_out = cm_r[CM-1];
  assign c_neg_out = cn_r[CM-1];

endmodule

[hdl/tan_div.sv]
// Three-lane pipelined restoring divider, one quotient bit per stage and lane.
module tan_div #(
  parameter int COORD_WIDTH      = tan_pkg::TAN_COORD_WIDTH,
  parameter int NORMAL_FRAC_BITS = tan_pkg::TAN_NORMAL_FRAC_BITS,
  parameter int CM               = 2 * COORD_WIDTH + 2,
  parameter int QB               = NORMAL_FRAC_BITS + 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [CM-1:0]      m,
  input  logic [2:0][CM-1:0] c_mag,
  input  logic [2:0]         c_neg,
  output logic               out_valid,
  output logic [CM-1:0]      m_out,
  output logic [2:0][QB-1:0] quot,
  output logic [2:0]         c_neg_out
);

  localparam int DW = CM + QB;

  logic [QB-1:0]       v_r;
  logic [2:0][DW-1:0]  rem_r [QB-1];
  logic [2:0][QB-1:0]  q_r   [QB];
  logic [CM-1:0]       m_r   [QB];
  logic [2:0]          cn_r  [QB];

  for (genvar g = 0; g < QB; g++) begin : g_st
    logic [2:0][DW-1:0] rem_i, rem_nxt;
    logic [2:0][QB-1:0] q_i, q_nxt;
    logic [CM-1:0]      m_i;
    logic [2:0]         cn_i;
    logic               vi;
    logic [DW-1:0]      dv;

    if (g == 0) begin : g_first
      for (genvar k = 0; k < 3; k++) begin : g_lane
        assign rem_i[k] = DW'({c_mag[k], {NORMAL_FRAC_BITS{1'b0}}});
      end
      assign q_i  = '0;
      assign m_i  = m;
      assign cn_i = c_neg;
      assign vi   = in_valid;
    end else begin : g_next
      assign rem_i = rem_r[g-1];
      assign q_i   = q_r[g-1];
      assign m_i   = m_r[g-1];
      assign cn_i  = cn_r[g-1];
      assign vi    = v_r[g-1];
    end

    assign dv = DW'(m_i) << (QB - 1 - g);

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        if (dv <= rem_i[k]) begin
          rem_nxt[k] = rem_i[k] - dv;
          q_nxt[k]   = {q_i[k][QB-2:0], 1'b1};
        end else begin
          rem_nxt[k] = rem_i[k];
          q_nxt[k]   = {q_i[k][QB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[g]  <= q_nxt;
        m_r[g]  <= m_i;
        cn_r[g] <= cn_i;
      end
    end

    if (g < QB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[g] <= rem_nxt;
        end
      end
    end
  end

  assign out_valid = v_r[QB-1];
  assign m_out     = m_r[QB-1];
  assign quot      = q_r[QB-1];
  assign c_neg_out = cn_r[QB-1];

endmodule

[hdl/triangle_area_normal.sv]
// Top level of the triangle area and unit normal pipeline.
// A request on the in_ channel carries one triangle as three signed vertices.
// Each accepted request yields exactly one result on the out_ channel: the area
// as the magnitude of the half cross product of the edges, the unit normal with
// NORMAL_FRAC_BITS fraction bits, and a degenerate flag for zero area.
// Results leave in the order the requests arrived.
// A triangle passes in order through the cross product registers, the square
// registers, the square root stages, which yield one root bit each, the divider
// stages, which yield one quotient bit each, and the output register.
// Throughput is one triangle per cycle unless the output stalls; every stage
// is a register and no unit is shared between requests.
// The whole pipeline advances together; when the output register holds a
// result that the receiver does not take, every stage holds and in_ready falls.
// Nothing is lost or repeated during a stall.
// Reset clears every valid bit, so the block starts empty and ready.
module triangle_area_normal #(
  parameter int COORD_WIDTH      = tan_pkg::TAN_COORD_WIDTH,
  parameter int NORMAL_FRAC_BITS = tan_pkg::TAN_NORMAL_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [COORD_WIDTH-1:0]      in_v0_x,
  input  logic signed [COORD_WIDTH-1:0]      in_v0_y,
  input  logic signed [COORD_WIDTH-1:0]      in_v0_z,
  input  logic signed [COORD_WIDTH-1:0]      in_v1_x,
  input  logic signed [COORD_WIDTH-1:0]      in_v1_y,
  input  logic signed [COORD_WIDTH-1:0]      in_v1_z,
  input  logic signed [COORD_WIDTH-1:0]      in_v2_x,
  input  logic signed [COORD_WIDTH-1:0]      in_v2_y,
  input  logic signed [COORD_WIDTH-1:0]      in_v2_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2*COORD_WIDTH:0]             out_tri_area,
  output logic signed [NORMAL_FRAC_BITS+1:0] out_normal_x,
  output logic signed [NORMAL_FRAC_BITS+1:0] out_normal_y,
  output logic signed [NORMAL_FRAC_BITS+1:0] out_normal_z,
  output logic                               out_degenerate
);

  localparam int CM = 2 * COORD_WIDTH + 2;
  localparam int SW = 2 * CM;
  localparam int QB = NORMAL_FRAC_BITS + 2;
  localparam logic signed [QB-1:0] NMAX = QB'(1) << NORMAL_FRAC_BITS;
  localparam logic signed [QB-1:0] NMIN = -NMAX;

  logic               en;
  logic               cr_valid, sq_valid, rt_valid, dv_valid;
  logic [2:0][CM-1:0] cr_mag, sq_mag, rt_mag;
  logic [2:0]         cr_neg, sq_neg, rt_neg, dv_neg;
  logic [SW-1:0]      sq_sum;
  logic [CM-1:0]      rt_root, dv_m;
  logic [2:0][QB-1:0] dv_quot;

  logic               out_valid_r;
  logic [CM-2:0]      area_r;
  logic [2:0][QB-1:0] normal_r, normal_nxt;
  logic               deg_r, deg_nxt;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  tan_cross #(.COORD_WIDTH(COORD_WIDTH), .CM(CM)) u_cross (
    .clk, .rst_n, .en,
    .in_valid,
    .v0_x(in_v0_x), .v0_y(in_v0_y), .v0_z(in_v0_z),
    .v1_x(in_v1_x), .v1_y(in_v1_y), .v1_z(in_v1_z),
    .v2_x(in_v2_x), .v2_y(in_v2_y), .v2_z(in_v2_z),
    .out_valid(cr_valid), .c_mag(cr_mag), .c_neg(cr_neg)
  );

  tan_square #(.COORD_WIDTH(COORD_WIDTH), .CM(CM), .SW(SW)) u_square (
    .clk, .rst_n, .en,
    .in_valid(cr_valid), .c_mag(cr_mag), .c_neg(cr_neg),
    .out_valid(sq_valid), .s(sq_sum), .c_mag_out(sq_mag), .c_neg_out(sq_neg)
  );

  tan_sqrt #(.COORD_WIDTH(COORD_WIDTH), .CM(CM), .SW(SW)) u_sqrt (
    .clk, .rst_n, .en,
    .in_valid(sq_valid), .s(sq_sum), .c_mag(sq_mag), .c_neg(sq_neg),
    .out_valid(rt_valid), .root(rt_root), .c_mag_out(rt_mag), .c_neg_out(rt_neg)
  );

  tan_div #(
    .COORD_WIDTH(COORD_WIDTH), .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS), .CM(CM), .QB(QB)
  ) u_div (
    .clk, .rst_n, .en,
    .in_valid(rt_valid), .m(rt_root), .c_mag(rt_mag), .c_neg(rt_neg),
    .out_valid(dv_valid), .m_out(dv_m), .quot(dv_quot), .c_neg_out(dv_neg)
  );

  always_comb begin
    deg_nxt = (dv_m[CM-1:1] == '0);
    for (int k = 0; k < 3; k++) begin
      if (deg_nxt) begin
        normal_nxt[k] = '0;
      end else if (dv_neg[k]) begin
        normal_nxt[k] = -dv_quot[k];
      end else begin
        normal_nxt[k] = dv_quot[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      area_r   <= dv_m[CM-1:1];
      normal_r <= normal_nxt;
      deg_r    <= deg_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_tri_area   = area_r;
  assign out_normal_x   = normal_r[0];
  assign out_normal_y   = normal_r[1];
  assign out_normal_z   = normal_r[2];
  assign out_degenerate = deg_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Output valid after reset.");

  a_deg_area: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_degenerate == (out_tri_area == '0)))
    else $error("Degenerate flag disagrees with area.");

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      (out_normal_x == '0) && (out_normal_y == '0) && (out_normal_z == '0))
    else $error("Degenerate triangle with nonzero normal.");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_normal_x <= NMAX) && (out_normal_x >= NMIN) &&
      (out_normal_y <= NMAX) && (out_normal_y >= NMIN) &&
      (out_normal_z <= NMAX) && (out_normal_z >= NMIN))
    else $error("Normal component outside unit range.");

  a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("Input taken while output stalled.");

endmodule
